// ===== sv/clsr_pkg.sv =====
`timescale 1ns / 1ps

package clsr_pkg;

  // Shuffle table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WARM_STEPS  = TABLE_DEPTH + 8;
  localparam int CNT_W       = $clog2(WARM_STEPS);
  localparam int VAL_W       = 31;

  // Generator constants (Schrage form: m = a*q + r)
  localparam logic [30:0] MOD_ONE = 31'd2147483563;
  localparam logic [30:0] MOD_TWO = 31'd2147483399;
  localparam logic [15:0] MUL_ONE = 16'd40014;
  localparam logic [15:0] MUL_TWO = 16'd40692;
  localparam logic [15:0] QUO_ONE = 16'd53668;
  localparam logic [15:0] QUO_TWO = 16'd52774;
  localparam logic [13:0] REM_ONE = 14'd12211;
  localparam logic [13:0] REM_TWO = 14'd3791;

  // Reciprocals of q for the z / q estimate
  localparam int          RECIP_SHIFT = 47;
  localparam logic [31:0] RECIP_ONE   = 32'((64'd1 << RECIP_SHIFT) / 64'(QUO_ONE));
  localparam logic [31:0] RECIP_TWO   = 32'((64'd1 << RECIP_SHIFT) / 64'(QUO_TWO));

  // Output fold and table bucket size
  localparam logic [30:0] FOLD_SPAN  = 31'(MOD_ONE - 31'd1);
  localparam logic [31:0] BUCKET     = 32'(64'd1 + 64'(FOLD_SPAN) / 64'(TABLE_DEPTH));
  localparam int          BKT_SHIFT  = 48;
  localparam logic [31:0] BKT_RECIP  = 32'((64'd1 << BKT_SHIFT) / 64'(BUCKET));

  // Reset values
  localparam logic [30:0] GEN_ONE_INIT = 31'd1;
  localparam logic [30:0] GEN_TWO_INIT = 31'd123456789;

  typedef enum logic {
    GEN_ONE,
    GEN_TWO
  } clsr_gen_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_ISSUE,
    ST_WARM_WAIT,
    ST_SETTLE,
    ST_DRAW_ISSUE,
    ST_DRAW_WAIT,
    ST_OUT
  } clsr_state_e;

  // Result of one generator step
  typedef struct packed {
    logic              done;
    logic [VAL_W-1:0]  value;
  } clsr_step_t;

endpackage

// ===== sv/clsr_ram.sv =====
`timescale 1ns / 1ps

module clsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/clsr_schrage.sv =====
`timescale 1ns / 1ps

// Three-stage Schrage step: v = a*(z mod q) - r*(z / q), folded by m if negative
module clsr_schrage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  clsr_pkg::clsr_gen_e     gen_sel_i,
  input  logic                    start_i,
  input  logic [30:0]             z_i,
  output clsr_pkg::clsr_step_t    step_o
);

  logic [15:0] mul_c;
  logic [15:0] quo_c;
  logic [13:0] rem_c;
  logic [30:0] mod_c;
  logic [31:0] recip_c;

  // Constant set of the selected generator
  always_comb begin
    unique case (gen_sel_i)
      clsr_pkg::GEN_ONE: begin
        mul_c   = clsr_pkg::MUL_ONE;
        quo_c   = clsr_pkg::QUO_ONE;
        rem_c   = clsr_pkg::REM_ONE;
        mod_c   = clsr_pkg::MOD_ONE;
        recip_c = clsr_pkg::RECIP_ONE;
      end
      clsr_pkg::GEN_TWO: begin
        mul_c   = clsr_pkg::MUL_TWO;
        quo_c   = clsr_pkg::QUO_TWO;
        rem_c   = clsr_pkg::REM_TWO;
        mod_c   = clsr_pkg::MOD_TWO;
        recip_c = clsr_pkg::RECIP_TWO;
      end
      default: begin
        mul_c   = clsr_pkg::MUL_ONE;
        quo_c   = clsr_pkg::QUO_ONE;
        rem_c   = clsr_pkg::REM_ONE;
        mod_c   = clsr_pkg::MOD_ONE;
        recip_c = clsr_pkg::RECIP_ONE;
      end
    endcase
  end

  // Stage 1: z times reciprocal of q
  logic [30:0] z1_q;
  logic [62:0] prod1_q;
  logic        v1_q;

  // Stage 2: quotient estimate plus one correction
  logic [15:0] hi_est;
  logic [31:0] hq;
  logic [31:0] lo_est;
  logic [15:0] hi_d;
  logic [15:0] lo_d;
  logic [15:0] hi2_q;
  logic [15:0] lo2_q;
  logic        v2_q;

  always_comb begin
    hi_est = prod1_q[62:clsr_pkg::RECIP_SHIFT];
    hq     = 32'(hi_est) * 32'(quo_c);
    lo_est = 32'(z1_q) - hq;
    if (lo_est >= 32'(quo_c)) begin
      hi_d = hi_est + 16'd1;
      lo_d = 16'(lo_est - 32'(quo_c));
    end else begin
      hi_d = hi_est;
      lo_d = lo_est[15:0];
    end
  end

  // Stage 3: a*lo - r*hi, add m when negative
  logic [32:0]        alo;
  logic [32:0]        hr;
  logic signed [32:0] v_raw;
  logic signed [32:0] v_fix;
  logic [30:0]        res3_q;
  logic               v3_q;

  always_comb begin
    alo   = 33'(mul_c) * 33'(lo2_q);
    hr    = 33'(hi2_q) * 33'(rem_c);
    v_raw = $signed(alo) - $signed(hr);
    if (v_raw[32]) begin
      v_fix = v_raw + $signed(33'(mod_c));
    end else begin
      v_fix = v_raw;
    end
  end

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Data pipeline
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      z1_q    <= z_i;
      prod1_q <= 63'(z_i) * 63'(recip_c);
    end
    if (v1_q) begin
      hi2_q <= hi_d;
      lo2_q <= lo_d;
    end
    if (v2_q) begin
      res3_q <= v_fix[30:0];
    end
  end

  assign step_o.done  = v3_q;
  assign step_o.value = res3_q;

endmodule

// ===== sv/combined_lcg_shuffle_rng.sv =====
`timescale 1ns / 1ps

// Combined two-generator LCG with a Bays-Durham shuffle table. Each input word
// asks for one draw (tuser 0) or a reseed from tdata and then a draw (tuser 1)
// and yields one output word carrying the draw. Both generators step in
// parallel in three-stage Schrage units, and the shuffle table sits in a
// registered-read RAM that is read and written back once per draw. A draw
// passes through the Schrage units, the table write-back and the output
// register before the next request is taken. A reseed runs the 40 warm-up
// steps (TABLE_DEPTH + 8) through the first unit one after another, then
// the draw. A finished word waits in the output register while the next
// request is taken; a new result that finds the previous word still
// unaccepted holds the block until the sink takes it. Table entries not
// yet written read as zero.
module combined_lcg_shuffle_rng (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] seed, [31] zero
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [30:0] rand_value, [31] zero
);

  localparam int DEPTH = clsr_pkg::TABLE_DEPTH;
  localparam int IW    = clsr_pkg::IDX_W;
  localparam int CW    = clsr_pkg::CNT_W;

  clsr_pkg::clsr_state_e state_q, state_d;

  logic [30:0]      gen_one_q;
  logic [30:0]      gen_two_q;
  logic [30:0]      last_out_q;
  logic [CW-1:0]    cnt_q;
  logic [IW-1:0]    idx_q;
  logic [IW:0]      est_q;
  logic             rd_valid_q;
  logic [DEPTH-1:0] tbl_valid_q;
  logic             out_valid_q;
  logic [30:0]      out_data_q;

  logic             in_accept;
  logic             is_reseed;
  logic [30:0]      seed_val;

  clsr_pkg::clsr_step_t step_one;
  clsr_pkg::clsr_step_t step_two;

  logic             start_one;
  logic             draw_issue;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [30:0]      ram_rdata;
  logic             out_load;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign is_reseed = s_axis_tuser[0];
  assign seed_val  = (s_axis_tdata[30:0] == 31'd0) ? 31'd1 : s_axis_tdata[30:0];

  // Table index from last output: reciprocal estimate, one correction, saturate
  logic [62:0]   bprod;
  logic [IW+1:0] est_plus;
  logic [40:0]   bound;
  logic [IW+1:0] quo;
  logic [IW-1:0] idx_now;

  always_comb begin
    bprod    = 63'(last_out_q) * 63'(clsr_pkg::BKT_RECIP);
    est_plus = {1'b0, est_q} + (IW+2)'(1);
    bound    = 41'(est_plus) * 41'(clsr_pkg::BUCKET);
    quo      = (41'(last_out_q) >= bound) ? est_plus : {1'b0, est_q};
    if (quo > (IW+2)'(DEPTH - 1)) begin
      idx_now = IW'(DEPTH - 1);
    end else begin
      idx_now = quo[IW-1:0];
    end
  end

  // Fold of table entry minus second generator
  logic [30:0]        entry;
  logic signed [32:0] diff;
  logic signed [32:0] diff_fix;

  always_comb begin
    entry = rd_valid_q ? ram_rdata : 31'd0;
    diff  = $signed({2'b00, entry}) - $signed({2'b00, step_two.value});
    if (diff[32] || (diff == 33'sd0)) begin
      diff_fix = diff + $signed({2'b00, clsr_pkg::FOLD_SPAN});
    end else begin
      diff_fix = diff;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clsr_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = is_reseed ? clsr_pkg::ST_WARM_ISSUE : clsr_pkg::ST_DRAW_WAIT;
        end
      end
      clsr_pkg::ST_WARM_ISSUE: state_d = clsr_pkg::ST_WARM_WAIT;
      clsr_pkg::ST_WARM_WAIT: begin
        if (step_one.done) begin
          state_d = (cnt_q == '0) ? clsr_pkg::ST_SETTLE : clsr_pkg::ST_WARM_ISSUE;
        end
      end
      clsr_pkg::ST_SETTLE:     state_d = clsr_pkg::ST_DRAW_ISSUE;
      clsr_pkg::ST_DRAW_ISSUE: state_d = clsr_pkg::ST_DRAW_WAIT;
      clsr_pkg::ST_DRAW_WAIT: begin
        if (step_one.done) begin
          state_d = clsr_pkg::ST_OUT;
        end
      end
      clsr_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = clsr_pkg::ST_IDLE;
        end
      end
      default: state_d = clsr_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    s_axis_tready = (state_q == clsr_pkg::ST_IDLE);
    draw_issue    = ((state_q == clsr_pkg::ST_IDLE) && in_accept && !is_reseed) ||
                    (state_q == clsr_pkg::ST_DRAW_ISSUE);
    start_one     = draw_issue || (state_q == clsr_pkg::ST_WARM_ISSUE);
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    if ((state_q == clsr_pkg::ST_WARM_WAIT) && step_one.done &&
        (cnt_q < CW'(DEPTH))) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[IW-1:0];
    end else if ((state_q == clsr_pkg::ST_DRAW_WAIT) && step_one.done) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q;
    end
    out_load = (state_q == clsr_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);
  end

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clsr_pkg::ST_IDLE;
      gen_one_q   <= clsr_pkg::GEN_ONE_INIT;
      gen_two_q   <= clsr_pkg::GEN_TWO_INIT;
      last_out_q  <= 31'd0;
      est_q       <= '0;
      cnt_q       <= '0;
      tbl_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      est_q   <= bprod[clsr_pkg::BKT_SHIFT + IW:clsr_pkg::BKT_SHIFT];

      if ((state_q == clsr_pkg::ST_IDLE) && in_accept && is_reseed) begin
        gen_one_q <= seed_val;
        gen_two_q <= seed_val;
        cnt_q     <= CW'(clsr_pkg::WARM_STEPS - 1);
      end

      if ((state_q == clsr_pkg::ST_WARM_WAIT) && step_one.done) begin
        gen_one_q <= step_one.value;
        cnt_q     <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          last_out_q <= step_one.value;
        end
      end

      if ((state_q == clsr_pkg::ST_DRAW_WAIT) && step_one.done) begin
        gen_one_q  <= step_one.value;
        gen_two_q  <= step_two.value;
        last_out_q <= diff_fix[30:0];
      end

      if (ram_we) begin
        tbl_valid_q[ram_waddr] <= 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Read-side capture and output word
  always_ff @(posedge clk_i) begin
    if (draw_issue) begin
      idx_q      <= idx_now;
      rd_valid_q <= tbl_valid_q[idx_now];
    end
    if (out_load) begin
      out_data_q <= last_out_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

  clsr_schrage u_gen_one (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gen_sel_i (clsr_pkg::GEN_ONE),
    .start_i   (start_one),
    .z_i       (gen_one_q),
    .step_o    (step_one)
  );

  clsr_schrage u_gen_two (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gen_sel_i (clsr_pkg::GEN_TWO),
    .start_i   (draw_issue),
    .z_i       (gen_two_q),
    .step_o    (step_two)
  );

  clsr_ram #(
    .WIDTH (clsr_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (step_one.value),
    .re_i    (draw_issue),
    .raddr_i (idx_now),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== sv/clsr_checker.sv =====
`timescale 1ns / 1ps

module clsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Draw value stays in the folded range, pad bit clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[31] && (m_axis_tdata[30:0] >= 31'd1) &&
                      (m_axis_tdata[30:0] <= 31'd2147483562))
    else $error("draw value out of range");

  // One request in flight: ready drops after an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");

  // No result can appear in the cycle right after a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // A reseed still holds ready low partway through the warm-up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> ##8 !s_axis_tready)
    else $error("reseed finished too soon");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (.*);
